@@ hw/rtl/moving_bar_test_pattern_top_macros.svh @@
// Assertion macros shared by the moving bar test pattern RTL.
`ifndef MOVING_BAR_TEST_PATTERN_TOP_MACROS_SVH
`define MOVING_BAR_TEST_PATTERN_TOP_MACROS_SVH
`ifndef SYNTH
`define MBTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MBTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define MBTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MBTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ hw/rtl/mbtp_pkg.sv @@
// Types, constants and helpers of the moving bar test pattern.
`default_nettype none
package mbtp_pkg;

	localparam int CFG_BITS        = 13;
	localparam int FRAME_BITS      = 32;
	localparam int COORD_BITS      = 12;
	localparam int COLOR_BITS      = 24;
	localparam int BAR_BITS        = CFG_BITS - 3;
	localparam int BAR_IDX_BITS    = 3;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = (FRAME_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int IN_BITS         = FRAME_BITS + 2 * COORD_BITS;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1920;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd1080;

	localparam logic [CFG_BITS:0] MARKER_WIDTH = 14'd8;
	localparam logic [CFG_BITS:0] BAND_HEIGHT  = 14'd6;

	localparam logic [COLOR_BITS-1:0] MARKER_COLOR = 24'hff8000;
	localparam logic [COLOR_BITS-1:0] BLANK_COLOR  = 24'h000000;

	localparam logic [COLOR_BITS-1:0] BAR_COLORS [8] = '{
		24'hffffff, 24'hffff00, 24'h00ffff, 24'h00ff00,
		24'hff00ff, 24'hff0000, 24'h0000ff, 24'h000000
	};

	typedef struct packed {
		logic [CFG_BITS-1:0] w;
		logic [CFG_BITS-1:0] h;
		logic [BAR_BITS-1:0] bar;
	} divisors_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [CFG_BITS-1:0]   rem_w;
		logic [CFG_BITS-1:0]   rem_h;
		logic [BAR_BITS-1:0]   rem_x;
		logic [COORD_BITS-1:0] quot_x;
	} div_data_t;

	function automatic logic [CFG_BITS-1:0] mod_step(
		input logic [CFG_BITS-1:0] r,
		input logic                b,
		input logic [CFG_BITS-1:0] d
	);
		logic [CFG_BITS:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[CFG_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mbtp_div_stage.sv @@
// One pipeline stage of restoring remainder and quotient steps.
`default_nettype none
module mbtp_div_stage #(
	parameter int FIRST_STEP = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mbtp_pkg::divisors_t  div,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  mbtp_pkg::div_data_t  in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output mbtp_pkg::div_data_t  out_data
);

	logic                valid_s1;
	mbtp_pkg::div_data_t data_s1;
	mbtp_pkg::div_data_t next_data;

	always_comb begin
		logic [mbtp_pkg::BAR_BITS:0] tx;
		int k;
		next_data = in_data;
		tx = '0;
		k = 0;
		for (int j = 0; j < mbtp_pkg::STEPS_PER_STAGE; j++) begin
			k = FIRST_STEP + j;
			if (k < mbtp_pkg::FRAME_BITS) begin
				next_data.rem_w = mbtp_pkg::mod_step(next_data.rem_w,
					in_data.frame[mbtp_pkg::FRAME_BITS-1-k], div.w);
				next_data.rem_h = mbtp_pkg::mod_step(next_data.rem_h,
					in_data.frame[mbtp_pkg::FRAME_BITS-1-k], div.h);
			end
			if (k < mbtp_pkg::COORD_BITS) begin
				tx = {next_data.rem_x, in_data.x[mbtp_pkg::COORD_BITS-1-k]};
				if (tx >= {1'b0, div.bar}) begin
					tx = tx - {1'b0, div.bar};
					next_data.quot_x = {next_data.quot_x[mbtp_pkg::COORD_BITS-2:0], 1'b1};
				end else begin
					next_data.quot_x = {next_data.quot_x[mbtp_pkg::COORD_BITS-2:0], 1'b0};
				end
				next_data.rem_x = tx[mbtp_pkg::BAR_BITS-1:0];
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= next_data;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mbtp_color.sv @@
// Remainder scaling, marker and band window tests and color selection.
`default_nettype none
module mbtp_color (
	input  wire                              clk,
	input  wire                              arst_n,
	input  mbtp_pkg::divisors_t              div,
	input  wire                              blank,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  mbtp_pkg::div_data_t              in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [mbtp_pkg::COLOR_BITS-1:0]  out_color
);

	logic                                valid_s1;
	logic [mbtp_pkg::COORD_BITS-1:0]     x_s1;
	logic [mbtp_pkg::COORD_BITS-1:0]     y_s1;
	logic [mbtp_pkg::CFG_BITS-1:0]       marker_s1;
	logic [mbtp_pkg::CFG_BITS-1:0]       band_s1;
	logic [mbtp_pkg::BAR_IDX_BITS-1:0]   bar_s1;
	logic                                valid_s2;
	logic [mbtp_pkg::COLOR_BITS-1:0]     color_s2;
	logic                                ready_s2;

	logic [mbtp_pkg::CFG_BITS-1:0]       marker_col;
	logic [mbtp_pkg::CFG_BITS-1:0]       band_y;
	logic [mbtp_pkg::CFG_BITS:0]         band_sum;
	logic [mbtp_pkg::CFG_BITS-1:0]       band_dbl;
	logic [mbtp_pkg::COLOR_BITS-1:0]     color;

	function automatic logic in_window(
		input logic [mbtp_pkg::COORD_BITS-1:0] pos,
		input logic [mbtp_pkg::CFG_BITS-1:0]   start,
		input logic [mbtp_pkg::CFG_BITS:0]     len,
		input logic [mbtp_pkg::CFG_BITS-1:0]   limit
	);
		logic [mbtp_pkg::CFG_BITS:0] p;
		logic [mbtp_pkg::CFG_BITS:0] e;
		p = {2'b00, pos};
		e = {1'b0, start} + len;
		return (p >= {1'b0, start} && p < e) ||
			(e > {1'b0, limit} && p < e - {1'b0, limit});
	endfunction

	always_comb begin
		marker_col = mbtp_pkg::mod_step(mbtp_pkg::mod_step(in_data.rem_w, 1'b0, div.w),
			1'b0, div.w);
		band_dbl = mbtp_pkg::mod_step(in_data.rem_h, 1'b0, div.h);
		band_sum = {1'b0, band_dbl} + {1'b0, in_data.rem_h};
		if (band_sum >= {1'b0, div.h}) begin
			band_sum = band_sum - {1'b0, div.h};
		end
		band_y = band_sum[mbtp_pkg::CFG_BITS-1:0];
	end

	always_comb begin
		color = mbtp_pkg::BAR_COLORS[bar_s1];
		if (in_window(x_s1, marker_s1, mbtp_pkg::MARKER_WIDTH, div.w)) begin
			color = mbtp_pkg::MARKER_COLOR;
		end
		if (in_window(y_s1, band_s1, mbtp_pkg::BAND_HEIGHT, div.h)) begin
			color = ~color;
		end
		if (blank) begin
			color = mbtp_pkg::BLANK_COLOR;
		end
	end

	assign ready_s2  = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || ready_s2;
	assign out_valid = valid_s2;
	assign out_color = color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1      <= in_data.x;
			y_s1      <= in_data.y;
			marker_s1 <= marker_col;
			band_s1   <= band_y;
			bar_s1    <= (div.bar != '0) ? in_data.quot_x[mbtp_pkg::BAR_IDX_BITS-1:0] : '0;
		end
		if (valid_s1 && ready_s2) begin
			color_s2 <= color;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/moving_bar_test_pattern_top.sv @@
// Top level of the moving color bar test pattern generator.
// Takes one pixel transaction (frame number, x, y) per clock unless stalled by
// backpressure and returns its 24-bit 0xRRGGBB color. Divider stages run the 32
// restoring remainder steps on the frame number (four per stage), followed by a
// wrap stage and a color stage. Backpressure stalls each stage only when it is
// full. frame_width and frame_height are written through cfg_wr_en/cfg_index/
// cfg_data; the user must write them only while no pixel is in flight, as the
// block does not enforce it. Values above MAX_WIDTH/MAX_HEIGHT are clamped.
`default_nettype none
`include "moving_bar_test_pattern_top_macros.svh"
module moving_bar_test_pattern_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire  [0:0]                       cfg_index,
	input  wire  [mbtp_pkg::CFG_BITS-1:0]    cfg_data,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// frame_number[31:0], pixel_x[43:32], pixel_y[55:44]
	input  wire  [mbtp_pkg::IN_BITS-1:0]     s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// pixel_color[23:0]
	output logic [mbtp_pkg::COLOR_BITS-1:0]  m_tdata
);

	localparam int CFG_MAX = (1 << mbtp_pkg::CFG_BITS) - 1;
	localparam logic [mbtp_pkg::CFG_BITS-1:0] WIDTH_CAP =
		(MAX_WIDTH > CFG_MAX) ? '1 : mbtp_pkg::CFG_BITS'(MAX_WIDTH);
	localparam logic [mbtp_pkg::CFG_BITS-1:0] HEIGHT_CAP =
		(MAX_HEIGHT > CFG_MAX) ? '1 : mbtp_pkg::CFG_BITS'(MAX_HEIGHT);

	logic [mbtp_pkg::CFG_BITS-1:0] frame_width_q;
	logic [mbtp_pkg::CFG_BITS-1:0] frame_height_q;
	mbtp_pkg::divisors_t           div;
	logic                          blank;

	logic                stage_valid [mbtp_pkg::DIV_STAGES+1];
	logic                stage_ready [mbtp_pkg::DIV_STAGES+1];
	mbtp_pkg::div_data_t stage_data  [mbtp_pkg::DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mbtp_pkg::WIDTH_RESET;
			frame_height_q <= mbtp_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbtp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mbtp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		div.w   = (frame_width_q > WIDTH_CAP) ? WIDTH_CAP : frame_width_q;
		div.h   = (frame_height_q > HEIGHT_CAP) ? HEIGHT_CAP : frame_height_q;
		div.bar = div.w[mbtp_pkg::CFG_BITS-1:3];
		blank   = (div.w == '0) || (div.h == '0);
	end

	assign stage_valid[0] = s_tvalid;
	assign stage_data[0]  = '{
		frame:   s_tdata[mbtp_pkg::FRAME_BITS-1:0],
		x:       s_tdata[mbtp_pkg::FRAME_BITS +: mbtp_pkg::COORD_BITS],
		y:       s_tdata[mbtp_pkg::FRAME_BITS + mbtp_pkg::COORD_BITS +: mbtp_pkg::COORD_BITS],
		default: '0
	};

	assign s_tready = stage_ready[0];

	for (genvar i = 0; i < mbtp_pkg::DIV_STAGES; i++) begin : g_div
		mbtp_div_stage #(
			.FIRST_STEP (i * mbtp_pkg::STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.div       (div),
			.in_valid  (stage_valid[i]),
			.in_ready  (stage_ready[i]),
			.in_data   (stage_data[i]),
			.out_valid (stage_valid[i+1]),
			.out_ready (stage_ready[i+1]),
			.out_data  (stage_data[i+1])
		);
	end

	mbtp_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.div       (div),
		.blank     (blank),
		.in_valid  (stage_valid[mbtp_pkg::DIV_STAGES]),
		.in_ready  (stage_ready[mbtp_pkg::DIV_STAGES]),
		.in_data   (stage_data[mbtp_pkg::DIV_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_color (m_tdata)
	);

	`MBTP_ASSERT(a_blank_black, clk, arst_n,
		(m_tvalid && (frame_width_q == '0 || frame_height_q == '0)) |->
		(m_tdata == mbtp_pkg::BLANK_COLOR), "empty frame gave a non-black pixel")
	`MBTP_ASSERT(a_ready_when_empty, clk, arst_n, !stage_valid[1] |-> s_tready,
		"input stalled with first stage empty")
	`MBTP_ASSERT_NEXT(a_accept_loads, clk, arst_n, s_tvalid && s_tready, stage_valid[1],
		"accepted transaction not captured")

endmodule
`default_nettype wire
